FILE: hdl/fos_pkg.sv
// ----------------------------------------------------------------------------
// fos_pkg
// Shared types and constants of the fuzzy obstacle steering pipeline.
// ----------------------------------------------------------------------------
package fos_pkg;

   localparam int unsigned DistWidth    = 8;
   localparam int unsigned HeadWidth    = 10;
   localparam int unsigned MembWidth    = 6;
   localparam int unsigned NumWidth     = 14;
   localparam int unsigned DenWidth     = 9;
   localparam int unsigned CmpWidth     = 15;
   localparam int unsigned NumSensors   = 5;
   localparam int unsigned ReqDataWidth = 56;
   localparam int unsigned RspDataWidth = 8;

   localparam logic [HeadWidth-1:0] HeadingReset = 10'd240;

   localparam logic [MembWidth-1:0] MembOne  = 6'd60;
   localparam logic [MembWidth-1:0] MembHalf = 6'd30;

   typedef logic [MembWidth-1:0] memb_type;

   typedef enum logic [2:0] {
      MOTION_LEFT         = 3'd0,
      MOTION_SLIGHT_LEFT  = 3'd1,
      MOTION_FORWARD      = 3'd2,
      MOTION_SLIGHT_RIGHT = 3'd3,
      MOTION_RIGHT        = 3'd4,
      MOTION_REVERSE      = 3'd5
   } motion_type;

   typedef struct packed {
      memb_type free_m;
      memb_type far_m;
      memb_type med_m;
      memb_type near_m;
   } dist_sets_type;

   typedef struct packed {
      dist_sets_type [NumSensors-1:0] obst;
      memb_type                       hl;
      memb_type                       hsl;
      memb_type                       hc;
      memb_type                       hsr;
      memb_type                       hr;
      logic                           right_dominant;
      logic                           left_dominant;
   } fuzz_type;

   typedef struct packed {
      memb_type left;
      memb_type sleft;
      memb_type fwd;
      memb_type sright;
      memb_type right;
      logic     rev;
   } rule_type;

   typedef struct packed {
      logic [NumWidth-1:0] num;
      logic [DenWidth-1:0] den;
      logic                rev;
   } sum_type;

   typedef struct packed {
      logic       pin_d;
      logic       pin_c;
      logic       pin_b;
      logic       pin_a;
      motion_type motion;
   } result_type;

endpackage

FILE: hdl/fuzzy_obstacle_steering_unit.sv
// ----------------------------------------------------------------------------
// fuzzy_obstacle_steering_unit
// Fuzzy steering controller: five obstacle readings and a heading in, one
// motion code and four motor pin levels out.
// ----------------------------------------------------------------------------
// Four-stage pipeline (fuzzify, rules, weighted sums, decision) that takes one
// sensor set per cycle while req_tready is high. A result passes the fuzzify,
// rules, sums and decision registers in turn before it is presented on rsp_.
// Each stage holds its own valid bit and stalls only when it is full and the
// stage after it is blocked, so rsp_tready low fills bubbles before it pushes
// back on req_tready. The target heading is written through the csr_ port,
// which is always ready; write it only while no item is in flight.
// ----------------------------------------------------------------------------
module fuzzy_obstacle_steering_unit (
   input  logic                                clock,
   input  logic                                reset,
   // dist_left, dist_center_left, dist_center, dist_center_right, dist_right,
   // heading (lowest bits first), zero fill
   input  logic [fos_pkg::ReqDataWidth-1:0]    req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // motion, pin_a, pin_b, pin_c, pin_d (lowest bits first), zero fill
   output logic [fos_pkg::RspDataWidth-1:0]    rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [fos_pkg::HeadWidth-1:0]       csr_data,
   input  logic                                csr_valid,
   output logic                                csr_ready
);
   import fos_pkg::*;

   logic [HeadWidth-1:0] desired_heading_ff;
   logic [DistWidth-1:0] dist_raw [NumSensors];
   logic [HeadWidth-1:0] heading;

   logic       fuzz_valid;
   logic       fuzz_ready;
   fuzz_type   fuzz_data;
   logic       rule_valid;
   logic       rule_ready;
   rule_type   rule_data;
   logic       sum_valid;
   logic       sum_ready;
   sum_type    sum_data;
   result_type result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         desired_heading_ff <= HeadingReset;
      end else if (csr_valid && csr_ready) begin
         desired_heading_ff <= csr_data;
      end
   end

   always_comb begin
      for (int i = 0; i < NumSensors; i++) begin
         dist_raw[i] = req_tdata[i*DistWidth +: DistWidth];
      end
      heading = req_tdata[NumSensors*DistWidth +: HeadWidth];
   end

   fos_fuzz_stage u_fuzz (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_tvalid),
      .in_ready        (req_tready),
      .dist_raw        (dist_raw),
      .heading         (heading),
      .desired_heading (desired_heading_ff),
      .out_valid       (fuzz_valid),
      .out_ready       (fuzz_ready),
      .out_data        (fuzz_data)
   );

   fos_rule_stage u_rule (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fuzz_valid),
      .in_ready  (fuzz_ready),
      .in_data   (fuzz_data),
      .out_valid (rule_valid),
      .out_ready (rule_ready),
      .out_data  (rule_data)
   );

   fos_sum_stage u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rule_valid),
      .in_ready  (rule_ready),
      .in_data   (rule_data),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .out_data  (sum_data)
   );

   fos_decide_stage u_decide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_ready  (sum_ready),
      .in_data   (sum_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (result)
   );

   assign rsp_tdata = {1'b0, result};

endmodule

FILE: hdl/fos_fuzz_stage.sv
// ----------------------------------------------------------------------------
// fos_fuzz_stage
// Fuzzifies the five distance readings and the heading error, one register.
// ----------------------------------------------------------------------------
module fos_fuzz_stage (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [fos_pkg::DistWidth-1:0]  dist_raw [fos_pkg::NumSensors],
   input  logic [fos_pkg::HeadWidth-1:0]  heading,
   input  logic [fos_pkg::HeadWidth-1:0]  desired_heading,
   output logic                           out_valid,
   input  logic                           out_ready,
   output fos_pkg::fuzz_type              out_data
);
   import fos_pkg::*;

   logic           valid_ff;
   fuzz_type       data_ff;
   fuzz_type       data_in;
   logic signed [10:0] e;
   logic signed [10:0] t_hl;
   logic signed [10:0] t_hsl;
   logic signed [10:0] t_hc;
   logic signed [10:0] t_hsr;
   logic signed [10:0] t_hr;
   logic [DistWidth-1:0] m34;
   logic [DistWidth-1:0] m01;

   function automatic dist_sets_type fuzz_dist(input logic [DistWidth-1:0] x);
      dist_sets_type d;
      logic [DistWidth-1:0] t;
      t = 8'd0;
      d = '0;
      if (x <= 8'd40) begin
         d.free_m = MembOne;
      end else if (x <= 8'd60) begin
         t = 8'd3 * (8'd60 - x);
         d.free_m = t[MembWidth-1:0];
      end
      if (x <= 8'd40) begin
         d.far_m = '0;
      end else if (x <= 8'd60) begin
         t = 8'd3 * (x - 8'd40);
         d.far_m = t[MembWidth-1:0];
      end else if (x <= 8'd65) begin
         d.far_m = MembOne;
      end else if (x <= 8'd85) begin
         t = 8'd3 * (8'd85 - x);
         d.far_m = t[MembWidth-1:0];
      end
      if (x <= 8'd65) begin
         d.med_m = '0;
      end else if (x <= 8'd85) begin
         t = 8'd3 * (x - 8'd65);
         d.med_m = t[MembWidth-1:0];
      end else if (x <= 8'd115) begin
         d.med_m = MembOne;
      end else if (x <= 8'd135) begin
         t = 8'd3 * (8'd135 - x);
         d.med_m = t[MembWidth-1:0];
      end
      if (x <= 8'd115) begin
         d.near_m = '0;
      end else if (x <= 8'd135) begin
         t = 8'd3 * (x - 8'd115);
         d.near_m = t[MembWidth-1:0];
      end else begin
         d.near_m = MembOne;
      end
      return d;
   endfunction

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      e = $signed({1'b0, desired_heading}) - $signed({1'b0, heading});

      if (e <= -11'sd60)      t_hl = 11'sd60;
      else if (e <= -11'sd30) t_hl = 11'sd2 * (-e - 11'sd30);
      else                    t_hl = 11'sd0;

      if (e <= -11'sd60)      t_hsl = 11'sd0;
      else if (e <= -11'sd30) t_hsl = 11'sd2 * (11'sd60 + e);
      else if (e <= -11'sd10) t_hsl = 11'sd60;
      else if (e <= 11'sd0)   t_hsl = 11'sd6 * (-e);
      else                    t_hsl = 11'sd0;

      if (e <= -11'sd10)      t_hc = 11'sd0;
      else if (e <= 11'sd0)   t_hc = 11'sd6 * (11'sd10 + e);
      else if (e <= 11'sd10)  t_hc = 11'sd6 * (11'sd10 - e);
      else                    t_hc = 11'sd0;

      if (e <= 11'sd0)        t_hsr = 11'sd0;
      else if (e <= 11'sd10)  t_hsr = 11'sd6 * e;
      else if (e <= 11'sd30)  t_hsr = 11'sd60;
      else if (e <= 11'sd60)  t_hsr = 11'sd2 * (11'sd60 - e);
      else                    t_hsr = 11'sd0;

      if (e <= 11'sd30)       t_hr = 11'sd0;
      else if (e <= 11'sd60)  t_hr = 11'sd2 * (e - 11'sd30);
      else                    t_hr = 11'sd60;

      m34 = (dist_raw[3] > dist_raw[4]) ? dist_raw[3] : dist_raw[4];
      m01 = (dist_raw[0] > dist_raw[1]) ? dist_raw[0] : dist_raw[1];

      for (int i = 0; i < NumSensors; i++) begin
         data_in.obst[i] = fuzz_dist(dist_raw[i]);
      end
      data_in.hl  = t_hl[MembWidth-1:0];
      data_in.hsl = t_hsl[MembWidth-1:0];
      data_in.hc  = t_hc[MembWidth-1:0];
      data_in.hsr = t_hsr[MembWidth-1:0];
      data_in.hr  = t_hr[MembWidth-1:0];
      data_in.right_dominant = (dist_raw[0] <= m34) && (dist_raw[1] <= m34);
      data_in.left_dominant  = (dist_raw[3] <= m01) && (dist_raw[4] <= m01);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: hdl/fos_rule_stage.sv
// ----------------------------------------------------------------------------
// fos_rule_stage
// Fires the steering rules and takes the maximum per output set.
// ----------------------------------------------------------------------------
module fos_rule_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  fos_pkg::fuzz_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output fos_pkg::rule_type out_data
);
   import fos_pkg::*;

   logic     valid_ff;
   rule_type data_ff;
   rule_type data_in;
   logic     ok34;
   logic     ok01;
   logic     near01;
   logic     near34;

   function automatic memb_type max2(input memb_type a, input memb_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic open_side(input dist_sets_type d);
      return (d.far_m >= MembHalf) || (d.free_m >= MembHalf);
   endfunction

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      ok34   = open_side(in_data.obst[3]) && open_side(in_data.obst[4]);
      ok01   = open_side(in_data.obst[0]) && open_side(in_data.obst[1]);
      near01 = (in_data.obst[0].near_m >= MembHalf) || (in_data.obst[1].near_m >= MembHalf);
      near34 = (in_data.obst[3].near_m >= MembHalf) || (in_data.obst[4].near_m >= MembHalf);

      data_in = '0;
      if (ok34) begin
         data_in.right = max2(data_in.right, in_data.hl);
         data_in.sright = max2(data_in.sright, in_data.hsl);
      end
      if (ok01) begin
         data_in.left = max2(data_in.left, in_data.hr);
         data_in.sleft = max2(data_in.sleft, in_data.hsr);
      end
      if ((in_data.hc >= MembHalf) && (in_data.obst[2].free_m >= MembHalf) &&
          open_side(in_data.obst[1]) && open_side(in_data.obst[3])) begin
         data_in.fwd = in_data.obst[2].free_m;
      end

      if (in_data.right_dominant) begin
         if ((in_data.obst[3].far_m >= MembHalf) || (in_data.obst[4].far_m >= MembHalf)) begin
            data_in.sleft = max2(data_in.sleft,
                                 max2(in_data.obst[3].far_m, in_data.obst[4].far_m));
         end
         if ((in_data.obst[3].med_m >= MembHalf) || (in_data.obst[4].med_m >= MembHalf)) begin
            data_in.left = max2(data_in.left,
                                max2(in_data.obst[3].med_m, in_data.obst[4].med_m));
         end
         if (near34) begin
            data_in.left = MembOne;
         end
         if (in_data.obst[2].far_m >= MembHalf) begin
            data_in.sleft = max2(data_in.sleft, in_data.obst[2].far_m);
         end
         if (in_data.obst[2].med_m >= MembHalf) begin
            data_in.left = max2(data_in.left, in_data.obst[2].med_m);
         end
      end

      if (in_data.left_dominant) begin
         if ((in_data.obst[0].far_m >= MembHalf) || (in_data.obst[1].far_m >= MembHalf)) begin
            data_in.sright = max2(data_in.sright,
                                  max2(in_data.obst[0].far_m, in_data.obst[1].far_m));
         end
         if ((in_data.obst[0].med_m >= MembHalf) || (in_data.obst[1].med_m >= MembHalf)) begin
            data_in.right = max2(data_in.right,
                                 max2(in_data.obst[0].med_m, in_data.obst[1].med_m));
         end
         if (near01) begin
            data_in.right = MembOne;
         end
         if (in_data.obst[2].far_m >= MembHalf) begin
            data_in.sright = max2(data_in.sright, in_data.obst[2].far_m);
         end
         if (in_data.obst[2].med_m >= MembHalf) begin
            data_in.right = max2(data_in.right, in_data.obst[2].med_m);
         end
      end

      data_in.rev = (in_data.obst[2].near_m >= MembHalf) || (near01 && near34);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: hdl/fos_sum_stage.sv
// ----------------------------------------------------------------------------
// fos_sum_stage
// Forms the weighted numerator and the denominator of the average.
// ----------------------------------------------------------------------------
module fos_sum_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  fos_pkg::rule_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output fos_pkg::sum_type  out_data
);
   import fos_pkg::*;

   logic    valid_ff;
   sum_type data_ff;
   sum_type data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      data_in.num = 14'd5  * NumWidth'(in_data.left)
                  + 14'd25 * NumWidth'(in_data.sleft)
                  + 14'd45 * NumWidth'(in_data.fwd)
                  + 14'd65 * NumWidth'(in_data.sright)
                  + 14'd85 * NumWidth'(in_data.right);
      data_in.den = DenWidth'(in_data.left) + DenWidth'(in_data.sleft)
                  + DenWidth'(in_data.fwd) + DenWidth'(in_data.sright)
                  + DenWidth'(in_data.right);
      data_in.rev = in_data.rev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

FILE: hdl/fos_decide_stage.sv
// ----------------------------------------------------------------------------
// fos_decide_stage
// Compares the average against the interval bounds and drives the pins.
// ----------------------------------------------------------------------------
module fos_decide_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  fos_pkg::sum_type    in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output fos_pkg::result_type out_data
);
   import fos_pkg::*;

   logic                valid_ff;
   result_type          data_ff;
   result_type          data_in;
   motion_type          motion;
   logic [CmpWidth-1:0] num_w;
   logic [CmpWidth-1:0] den_w;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      num_w = CmpWidth'(in_data.num);
      den_w = CmpWidth'(in_data.den);
      if (in_data.rev)                         motion = MOTION_REVERSE;
      else if (in_data.den == '0)              motion = MOTION_RIGHT;
      else if (num_w <= 15'd15 * den_w)        motion = MOTION_LEFT;
      else if (num_w <= 15'd35 * den_w)        motion = MOTION_SLIGHT_LEFT;
      else if (num_w <= 15'd55 * den_w)        motion = MOTION_FORWARD;
      else if (num_w <= 15'd75 * den_w)        motion = MOTION_SLIGHT_RIGHT;
      else                                     motion = MOTION_RIGHT;

      data_in.motion = motion;
      unique case (motion)
         MOTION_LEFT:         {data_in.pin_a, data_in.pin_b, data_in.pin_c, data_in.pin_d} = 4'b0110;
         MOTION_SLIGHT_LEFT:  {data_in.pin_a, data_in.pin_b, data_in.pin_c, data_in.pin_d} = 4'b0100;
         MOTION_FORWARD:      {data_in.pin_a, data_in.pin_b, data_in.pin_c, data_in.pin_d} = 4'b0101;
         MOTION_SLIGHT_RIGHT: {data_in.pin_a, data_in.pin_b, data_in.pin_c, data_in.pin_d} = 4'b0001;
         MOTION_RIGHT:        {data_in.pin_a, data_in.pin_b, data_in.pin_c, data_in.pin_d} = 4'b1001;
         MOTION_REVERSE:      {data_in.pin_a, data_in.pin_b, data_in.pin_c, data_in.pin_d} = 4'b1010;
         default:             {data_in.pin_a, data_in.pin_b, data_in.pin_c, data_in.pin_d} = 4'b0000;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule
